/* rtl/decimal_digit_sort_descending_unit_defines.svh */
// Assertion macros for the decimal digit sort unit.
// Used by files that carry concurrent checks; expects clk and rst in scope.
`ifndef DECIMAL_DIGIT_SORT_DESCENDING_UNIT_DEFINES_SVH
`define DECIMAL_DIGIT_SORT_DESCENDING_UNIT_DEFINES_SVH

// Check that is ignored while reset is high.
`define DSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define DSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dsd_pkg.sv */
// Shared constants, types and helpers for the decimal digit sort unit.
// No dependencies.
package dsd_pkg;

  localparam int VALUE_W    = 32;
  localparam int RESULT_W   = 34;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  // a positive 32-bit value has at most ten decimal digits
  localparam int DEC_SLOTS  = 10;
  localparam int NUM_DIGITS = (MAX_DIGITS < DEC_SLOTS) ? MAX_DIGITS : DEC_SLOTS;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int NUM_PAIRS  = (NUM_DIGITS + 1) / 2;
  // input reg, one stage per digit, count, prefix, bcd, pair sum, output
  localparam int LATENCY    = NUM_DIGITS + 6;

  // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  localparam logic [RESULT_W-1:0] RESULT_MAX = 34'd9999999999;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef struct packed {
    logic                            valid;
    logic [NUM_DIGITS-1:0]           present;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit;
  } extract_t;

  typedef struct packed {
    logic                  valid;
    logic [CNT_W-1:0]      total;
    logic [8:0][CNT_W-1:0] cum;   // count of digits <= d, for d = 0..8
  } tally_t;

  function automatic logic [RESULT_W-1:0] pow10(input int n);
    logic [RESULT_W-1:0] p;
    p = RESULT_W'(1);
    for (int i = 0; i < DEC_SLOTS; i++) begin
      if (i < n) begin
        p = p * RESULT_W'(10);
      end
    end
    return p;
  endfunction

endpackage

/* rtl/dsd_extract.sv */
// Digit extraction pipeline: one decimal digit peeled per stage.
// Depends on dsd_pkg.
module dsd_extract
  import dsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [VALUE_W-1:0] value,
  output extract_t           ext
);

  logic [NUM_DIGITS:0]                vld;
  logic [VALUE_W-1:0]                 rest [0:NUM_DIGITS];
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digs [0:NUM_DIGITS];
  logic [NUM_DIGITS-1:0]              pres [0:NUM_DIGITS];

  // non-positive input is treated as zero: no digit becomes present
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= take;
    end
    rest[0] <= (value[VALUE_W-1] == 1'b0) ? value : '0;
    digs[0] <= '0;
    pres[0] <= '0;
  end

  for (genvar k = 1; k <= NUM_DIGITS; k++) begin : g_peel
    logic [2*VALUE_W-1:0]               prod;
    logic [VALUE_W-1:0]                 quo;
    logic [VALUE_W-1:0]                 rem;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digs_next;
    logic [NUM_DIGITS-1:0]              pres_next;

    always_comb begin
      prod = {{VALUE_W{1'b0}}, rest[k-1]} * {{VALUE_W{1'b0}}, RECIP};
      quo  = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
      rem  = rest[k-1] - ((quo << 3) + (quo << 1));
      digs_next        = digs[k-1];
      digs_next[k-1]   = rem[DIGIT_W-1:0];
      pres_next        = pres[k-1];
      pres_next[k-1]   = (rest[k-1] != '0);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rest[k] <= quo;
      digs[k] <= digs_next;
      pres[k] <= pres_next;
    end
  end

  assign ext.valid   = vld[NUM_DIGITS];
  assign ext.present = pres[NUM_DIGITS];
  assign ext.digit   = digs[NUM_DIGITS];

endmodule

/* rtl/dsd_tally.sv */
// Digit histogram and its running (prefix) counts, two stages.
// Depends on dsd_pkg.
module dsd_tally
  import dsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  extract_t ext,
  output tally_t   tly
);

  logic                 cnt_valid;
  logic [9:0][CNT_W-1:0] cnt;
  logic [9:0][CNT_W-1:0] cnt_next;
  tally_t               tly_next;

  always_comb begin
    cnt_next = '0;
    for (int d = 0; d < 10; d++) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        cnt_next[d] = cnt_next[d]
                    + CNT_W'(ext.present[i] && (ext.digit[i] == DIGIT_W'(d)));
      end
    end
  end

  always_comb begin
    cnt_t run;
    run = '0;
    tly_next.valid = cnt_valid;
    tly_next.cum   = '0;
    for (int d = 0; d < 9; d++) begin
      run = run + cnt[d];
      tly_next.cum[d] = run;
    end
    tly_next.total = run + cnt[9];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= 1'b0;
      tly.valid <= 1'b0;
    end else begin
      cnt_valid <= ext.valid;
      tly.valid <= tly_next.valid;
    end
    cnt       <= cnt_next;
    tly.total <= tly_next.total;
    tly.cum   <= tly_next.cum;
  end

endmodule

/* rtl/dsd_rebuild.sv */
// Rebuilds the sorted number: BCD digits from prefix counts, then weighted sum.
// Depends on dsd_pkg.
module dsd_rebuild
  import dsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tally_t              tly,
  output logic                done,
  output logic [RESULT_W-1:0] sorted_value
);

  logic                                bcd_valid;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  bcd;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  bcd_next;
  logic                                part_valid;
  logic [NUM_PAIRS-1:0][RESULT_W-1:0]  part;
  logic [NUM_PAIRS-1:0][RESULT_W-1:0]  part_next;
  logic [RESULT_W-1:0]                 sum_next;

  // Low-end position j holds the number of digit values d whose running
  // count is <= j; positions at or above the digit total are empty.
  always_comb begin
    digit_t n;
    bcd_next = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      n = '0;
      for (int d = 0; d < 9; d++) begin
        n = n + DIGIT_W'(tly.cum[d] <= CNT_W'(j));
      end
      bcd_next[j] = (CNT_W'(j) < tly.total) ? n : '0;
    end
  end

  always_comb begin
    part_next = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      part_next[p] = RESULT_W'(bcd[2*p]) * pow10(2*p);
      if (2*p + 1 < NUM_DIGITS) begin
        part_next[p] = part_next[p] + RESULT_W'(bcd[2*p+1]) * pow10(2*p + 1);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      sum_next = sum_next + part[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcd_valid  <= 1'b0;
      part_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      bcd_valid  <= tly.valid;
      part_valid <= bcd_valid;
      done       <= part_valid;
    end
    bcd          <= bcd_next;
    part         <= part_next;
    sorted_value <= sum_next;
  end

endmodule

/* rtl/decimal_digit_sort_descending_unit.sv */
// Top level of the decimal digit sort unit (descending digit order).
// Depends on dsd_pkg, dsd_extract, dsd_tally, dsd_rebuild and the defines header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | start, busy (out)    | value        [31:0] signed
//  result   | done (strobe)        | sorted_value [33:0]
//
// Each item passes the input register, one digit peel stage per decimal
// digit, then the count, prefix, BCD, pair-sum and output stages.
// One item may enter every cycle while busy is low; every item gives exactly one result.
// rst is synchronous; busy is a registered copy of rst, so it rises and falls in the cycle after rst does.
// The pipeline never stalls: done is a one-cycle strobe, not held.
`include "decimal_digit_sort_descending_unit_defines.svh"

module decimal_digit_sort_descending_unit
  import dsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [VALUE_W-1:0]  value,
  output logic                done,
  output logic [RESULT_W-1:0] sorted_value
);

  logic     take;
  extract_t ext;
  tally_t   tly;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign take = start && !busy;

  dsd_extract u_extract (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .value (value),
    .ext   (ext)
  );

  dsd_tally u_tally (
    .clk (clk),
    .rst (rst),
    .ext (ext),
    .tly (tly)
  );

  dsd_rebuild u_rebuild (
    .clk          (clk),
    .rst          (rst),
    .tly          (tly),
    .done         (done),
    .sorted_value (sorted_value)
  );

  `DSD_ASSERT(a_fixed_latency, take |-> ##LATENCY done, "result missing at fixed latency")
  `DSD_ASSERT(a_neg_zero, (take && value[VALUE_W-1]) |-> ##LATENCY (sorted_value == '0), "negative input gave nonzero result")
  `DSD_ASSERT(a_range, done |-> (sorted_value <= RESULT_MAX), "result out of range")
  `DSD_ASSERT_RST(a_reset, rst |=> (busy && !done), "reset did not clear pipeline")

endmodule
